// ----- rtl/mavs_pkg.sv -----
// Shared types and constants of the multi vehicle arming supervisor.
// Used by every module of the block but mavs_ram; depends on nothing.
package mavs_pkg;

   localparam int MAX_DRONES = 8;
   localparam int IDX_W      = (MAX_DRONES > 1) ? $clog2(MAX_DRONES) : 1;
   localparam int CNT_W      = $clog2(MAX_DRONES + 1);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_VEHICLE_CNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABILITY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEP      = 3'd4;

   localparam logic [3:0]  RST_VEHICLE_CNT  = 4'd3;
   localparam logic [15:0] RST_STABILITY    = 16'd15;
   localparam logic [19:0] RST_ARM_TIMEOUT  = 20'd15000;
   localparam logic [19:0] RST_PEER_TIMEOUT = 20'd1500;
   localparam logic [15:0] RST_MIN_SEP      = 16'd3000;

   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [1:0] EV_STATUS    = 2'd0;
   localparam logic [1:0] EV_CLEARANCE = 2'd1;
   localparam logic [1:0] EV_ARM_CMD   = 2'd2;
   localparam logic [1:0] EV_MISSION   = 2'd3;

   localparam logic [1:0] MODE_MESH   = 2'd0;
   localparam logic [1:0] MODE_ARMING = 2'd1;
   localparam logic [1:0] MODE_ARMED  = 2'd2;
   localparam logic [1:0] MODE_FAULT  = 2'd3;

   localparam logic [7:0] ARM_STATE_ARMED = 8'd2;
   localparam logic [3:0] TICK_LAST_PHASE = 4'd9;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

   typedef struct packed {
      logic              cmd;
      logic [3:0]        topic_slot;
      logic [7:0]        reported_id;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic              coords_finite;
      logic [7:0]        reported_arm_state;
      logic [31:0]       time_ms;
   } req_data_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [3:0] target_drone;
      logic [1:0] manager_state;
      logic       report_rejected;
      logic       last_of_run;
   } rsp_data_type;

   typedef struct packed {
      logic [3:0]  vehicle_cnt;
      logic [15:0] stability_reports;
      logic [19:0] arm_timeout_ms;
      logic [19:0] peer_timeout_ms;
      logic [15:0] min_separation_mm;
   } cfg_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic               seen;
      logic               armed;
      logic [15:0]        count;
      logic [31:0]        stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

endpackage

// ----- rtl/mavs_ram.sv -----
// Generic single write, single read RAM with registered read data.
// Standalone; no package needed.
module mavs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mavs_ctrl.sv -----
// Sequencer of the supervisor: report read-modify-write, tick scan, pair walk
// and event emission. Uses mavs_pkg; drives the two per-vehicle RAM copies.
module mavs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mavs_pkg::req_data_type     req_data,
   output logic                       busy,
   input  mavs_pkg::cfg_type          cfg,
   output mavs_pkg::ram_wr_type       ram_wr,
   output logic [mavs_pkg::IDX_W-1:0] rd_addr_a,
   output logic [mavs_pkg::IDX_W-1:0] rd_addr_b,
   input  mavs_pkg::entry_type        rd_a,
   input  mavs_pkg::entry_type        rd_b,
   output logic                       rsp_valid,
   output mavs_pkg::rsp_data_type     rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_RPT_RD, S_RPT_WR, S_SC_RD, S_SC_CHK, S_PR_RD, S_PR_DIFF,
      S_PR_SQ, S_PR_CMP, S_DECIDE, S_EM_CLR, S_EM_CMD, S_EM_MR, S_EM_STAT
   } state_type;

   localparam int MAXD  = mavs_pkg::MAX_DRONES;
   localparam int IDX_W = mavs_pkg::IDX_W;
   localparam int CNT_W = mavs_pkg::CNT_W;

   state_type                state_ff, state_in;
   mavs_pkg::req_data_type   req_ff, req_in;
   logic [CNT_W-1:0]         idx_ff, idx_in, jdx_ff, jdx_in;
   logic                     fail_ff, fail_in, rej_ff, rej_in;
   logic [MAXD-1:0]          armed_vec_ff, armed_vec_in;
   logic [MAXD-1:0]          valid_ff, valid_in;
   logic                     va_ff, vb_ff;
   logic [31:0]              lim_ff, lim_in;
   logic [24:0]              dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic [49:0]              sqx_ff, sqy_ff, sqz_ff, sqx_in, sqy_in, sqz_in;
   logic [1:0]               mode_ff, mode_in;
   logic [3:0]               tick_phase_ff, tick_phase_in;
   logic [31:0]              phase_start_ff, phase_start_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mavs_pkg::rsp_data_type   rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]         n_use, n_last;
   logic [31:0]              num32;
   mavs_pkg::entry_type      ent_a, ent_b, ent_new;
   logic [MAXD-1:0]          in_use;
   logic                     all_armed, reject, accept;
   logic [51:0]              dist2;
   logic [31:0]              age;

   function automatic logic [24:0] abs_diff(input logic signed [23:0] a,
                                            input logic signed [23:0] b);
      logic signed [24:0] d;
      d = {a[23], a} - {b[23], b};
      return d[24] ? 25'(-d) : 25'(d);
   endfunction

   // clamp the vehicle count to 1..MAX_DRONES
   always_comb begin
      num32 = 32'(cfg.vehicle_cnt);
      if (num32 == 32'd0) begin
         n_use = CNT_W'(1);
      end else if (num32 > 32'(MAXD)) begin
         n_use = CNT_W'(MAXD);
      end else begin
         n_use = CNT_W'(num32);
      end
      n_last = n_use - CNT_W'(1);
      for (int k = 0; k < MAXD; k++) begin
         in_use[k] = (32'(k) < 32'(n_use));
      end
   end

   assign ent_a     = va_ff ? rd_a : '0;
   assign ent_b     = vb_ff ? rd_b : '0;
   assign all_armed = &(armed_vec_ff | ~in_use);
   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign rd_addr_a = idx_ff[IDX_W-1:0];
   assign rd_addr_b = jdx_ff[IDX_W-1:0];
   assign dist2     = 52'(sqx_ff) + 52'(sqy_ff) + 52'(sqz_ff);
   assign age       = req_ff.time_ms - ent_a.stamp;

   assign reject = (req_data.topic_slot == 4'd0)
                || (32'(req_data.topic_slot) > 32'(n_use))
                || (req_data.reported_id != {4'd0, req_data.topic_slot})
                || !req_data.coords_finite;

   always_comb begin
      ent_new       = ent_a;
      ent_new.x     = req_ff.pos_x;
      ent_new.y     = req_ff.pos_y;
      ent_new.z     = req_ff.pos_z;
      ent_new.seen  = 1'b1;
      ent_new.armed = (req_ff.reported_arm_state == mavs_pkg::ARM_STATE_ARMED);
      ent_new.stamp = req_ff.time_ms;
      if (ent_a.count != mavs_pkg::COUNT_MAX) begin
         ent_new.count = ent_a.count + 16'd1;
      end
      ram_wr.en   = (state_ff == S_RPT_WR);
      ram_wr.addr = idx_ff[IDX_W-1:0];
      ram_wr.data = ent_new;
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      idx_in         = idx_ff;
      jdx_in         = jdx_ff;
      fail_in        = fail_ff;
      rej_in         = rej_ff;
      armed_vec_in   = armed_vec_ff;
      valid_in       = valid_ff;
      lim_in         = lim_ff;
      dx_in          = abs_diff(ent_a.x, ent_b.x);
      dy_in          = abs_diff(ent_a.y, ent_b.y);
      dz_in          = abs_diff(ent_a.z, ent_b.z);
      sqx_in         = dx_ff * dx_ff;
      sqy_in         = dy_ff * dy_ff;
      sqz_in         = dz_ff * dz_ff;
      mode_in        = mode_ff;
      tick_phase_in  = tick_phase_ff;
      phase_start_in = phase_start_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = '0;
      rsp_data_in.manager_state = mode_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               rej_in = 1'b0;
               if (req_data.cmd == mavs_pkg::CMD_REPORT) begin
                  if (reject) begin
                     rej_in   = 1'b1;
                     state_in = S_EM_STAT;
                  end else begin
                     idx_in   = CNT_W'(req_data.topic_slot - 4'd1);
                     state_in = S_RPT_RD;
                  end
               end else begin
                  tick_phase_in = (tick_phase_ff >= mavs_pkg::TICK_LAST_PHASE) ?
                                  4'd0 : tick_phase_ff + 4'd1;
                  idx_in       = '0;
                  fail_in      = 1'b0;
                  armed_vec_in = '0;
                  lim_in       = {16'd0, cfg.min_separation_mm} *
                                 {16'd0, cfg.min_separation_mm};
                  state_in     = S_SC_RD;
               end
            end
         end
         S_RPT_RD: state_in = S_RPT_WR;
         S_RPT_WR: begin
            valid_in[idx_ff[IDX_W-1:0]] = 1'b1;
            state_in = S_EM_STAT;
         end
         S_SC_RD: state_in = S_SC_CHK;
         S_SC_CHK: begin
            armed_vec_in[idx_ff[IDX_W-1:0]] = ent_a.armed;
            if (!ent_a.seen || (ent_a.count < cfg.stability_reports)
                || (age > 32'(cfg.peer_timeout_ms))) begin
               fail_in = 1'b1;
            end
            if (idx_ff == n_last) begin
               if ((mode_ff == mavs_pkg::MODE_MESH) && !fail_in && (n_use > CNT_W'(1))) begin
                  idx_in   = '0;
                  jdx_in   = CNT_W'(1);
                  state_in = S_PR_RD;
               end else begin
                  state_in = S_DECIDE;
               end
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_SC_RD;
            end
         end
         S_PR_RD:   state_in = S_PR_DIFF;
         S_PR_DIFF: state_in = S_PR_SQ;
         S_PR_SQ:   state_in = S_PR_CMP;
         S_PR_CMP: begin
            if (dist2 < 52'(lim_ff)) begin
               fail_in  = 1'b1;
               state_in = S_DECIDE;
            end else if (jdx_ff == n_last) begin
               if (idx_ff == n_last - CNT_W'(1)) begin
                  state_in = S_DECIDE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  jdx_in   = idx_ff + CNT_W'(2);
                  state_in = S_PR_RD;
               end
            end else begin
               jdx_in   = jdx_ff + CNT_W'(1);
               state_in = S_PR_RD;
            end
         end
         S_DECIDE: begin
            state_in = S_EM_STAT;
            case (mode_ff)
               mavs_pkg::MODE_MESH: begin
                  if (!fail_ff) begin
                     mode_in        = mavs_pkg::MODE_ARMING;
                     phase_start_in = req_ff.time_ms;
                     state_in       = S_EM_CLR;
                  end
               end
               mavs_pkg::MODE_ARMING: begin
                  if (all_armed) begin
                     mode_in  = mavs_pkg::MODE_ARMED;
                     state_in = S_EM_MR;
                  end else begin
                     if (tick_phase_ff == 4'd0) begin
                        state_in = S_EM_CLR;
                     end
                     if ((req_ff.time_ms - phase_start_ff) > 32'(cfg.arm_timeout_ms)) begin
                        mode_in = mavs_pkg::MODE_FAULT;
                     end
                  end
               end
               default: state_in = S_EM_STAT;
            endcase
         end
         S_EM_CLR: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.event_kind = mavs_pkg::EV_CLEARANCE;
            idx_in                 = '0;
            state_in               = S_EM_CMD;
         end
         S_EM_CMD: begin
            // one slot per cycle; send only to the unarmed ones
            if (!armed_vec_ff[idx_ff[IDX_W-1:0]]) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.event_kind   = mavs_pkg::EV_ARM_CMD;
               rsp_data_in.target_drone = 4'(idx_ff + CNT_W'(1));
            end
            if (idx_ff == n_last) begin
               state_in = S_EM_STAT;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_EM_MR: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.event_kind = mavs_pkg::EV_MISSION;
            state_in               = S_EM_STAT;
         end
         S_EM_STAT: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.event_kind      = mavs_pkg::EV_STATUS;
            rsp_data_in.report_rejected = rej_ff;
            rsp_data_in.last_of_run     = 1'b1;
            state_in                    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= '0;
         mode_ff        <= mavs_pkg::MODE_MESH;
         tick_phase_ff  <= 4'd0;
         phase_start_ff <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         mode_ff        <= mode_in;
         tick_phase_ff  <= tick_phase_in;
         phase_start_ff <= phase_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      fail_ff      <= fail_in;
      rej_ff       <= rej_in;
      armed_vec_ff <= armed_vec_in;
      lim_ff       <= lim_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dz_ff        <= dz_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      sqz_ff       <= sqz_in;
      rsp_data_ff  <= rsp_data_in;
      // valid bit lines up with the registered RAM read
      va_ff        <= valid_ff[idx_ff[IDX_W-1:0]];
      vb_ff        <= valid_ff[jdx_ff[IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/multi_vehicle_arming_supervisor.sv -----
// Top level of the multi vehicle arming supervisor: register file, two copies
// of the per-vehicle RAM and the sequencer. Uses mavs_pkg, mavs_ram, mavs_ctrl.
//
// A beat on req is taken when start is high and busy is low; busy then stays
// high until the cycle in which the last result (status, last_of_run set) is
// shown, and the next beat can be taken at the end of that cycle. A report
// passes through memory read, write back and status before the next beat
// can be taken. A tick scans the vehicles one at a time (read, check) through
// the memory's read port; in mesh check, if the scan found no failure, it
// then walks every vehicle pair (read, difference, square, compare), stopping
// at the first failure, and emits commands at one slot per cycle. Results
// appear as one-cycle strobes on rsp_valid and cannot be held off.
// Per-vehicle state starts cleared through valid bits, so no clearing pass
// follows reset.
module multi_vehicle_arming_supervisor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  mavs_pkg::req_data_type              req_data,
   output logic                                busy,
   output logic                                rsp_valid,
   output mavs_pkg::rsp_data_type              rsp_data,
   input  logic                                csr_we,
   input  logic [mavs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mavs_pkg::CSR_W-1:0]          csr_wdata
);

   mavs_pkg::cfg_type               cfg_ff, cfg_in;
   mavs_pkg::ram_wr_type            ram_wr;
   logic [mavs_pkg::IDX_W-1:0]      rd_addr_a, rd_addr_b;
   logic [mavs_pkg::ENTRY_W-1:0]    rd_bits_a, rd_bits_b;
   mavs_pkg::entry_type             rd_a, rd_b;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mavs_pkg::CSR_VEHICLE_CNT:  cfg_in.vehicle_cnt       = csr_wdata[3:0];
            mavs_pkg::CSR_STABILITY:    cfg_in.stability_reports = csr_wdata[15:0];
            mavs_pkg::CSR_ARM_TIMEOUT:  cfg_in.arm_timeout_ms    = csr_wdata;
            mavs_pkg::CSR_PEER_TIMEOUT: cfg_in.peer_timeout_ms   = csr_wdata;
            mavs_pkg::CSR_MIN_SEP:      cfg_in.min_separation_mm = csr_wdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vehicle_cnt       <= mavs_pkg::RST_VEHICLE_CNT;
         cfg_ff.stability_reports <= mavs_pkg::RST_STABILITY;
         cfg_ff.arm_timeout_ms    <= mavs_pkg::RST_ARM_TIMEOUT;
         cfg_ff.peer_timeout_ms   <= mavs_pkg::RST_PEER_TIMEOUT;
         cfg_ff.min_separation_mm <= mavs_pkg::RST_MIN_SEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // both copies take every write so both members of a pair can be read in the same cycle
   mavs_ram #(
      .WIDTH (mavs_pkg::ENTRY_W),
      .DEPTH (mavs_pkg::MAX_DRONES)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_bits_a)
   );

   mavs_ram #(
      .WIDTH (mavs_pkg::ENTRY_W),
      .DEPTH (mavs_pkg::MAX_DRONES)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_bits_b)
   );

   assign rd_a = mavs_pkg::entry_type'(rd_bits_a);
   assign rd_b = mavs_pkg::entry_type'(rd_bits_b);

   mavs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .cfg       (cfg_ff),
      .ram_wr    (ram_wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/mavs_checker.sv -----
// Port-level checks of the supervisor, bound to the top level.
// Uses mavs_pkg.
module mavs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input mavs_pkg::rsp_data_type         rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |=> !rsp_valid)
      else $error("result beat right after end of run");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |-> rsp_data.event_kind == mavs_pkg::EV_STATUS)
      else $error("run ends on a non-status beat");

   a_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind != mavs_pkg::EV_ARM_CMD |->
      rsp_data.target_drone == 4'd0)
      else $error("target set on non-command beat");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.report_rejected |-> rsp_data.last_of_run)
      else $error("reject flag off the status beat");

endmodule

bind multi_vehicle_arming_supervisor mavs_checker u_mavs_checker (.*);

// ----- test/tb.sv -----
// Self-checking bench for multi_vehicle_arming_supervisor: directed and random
// report/tick beats, results checked against an in-bench supervisor model.
// Depends on mavs_pkg and the RTL top level only.
module tb;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   mavs_pkg::req_data_type           req_data = '0;
   logic                             busy;
   logic                             rsp_valid;
   mavs_pkg::rsp_data_type           rsp_data;
   logic                             csr_we = 1'b0;
   logic [mavs_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [mavs_pkg::CSR_W-1:0]       csr_wdata = '0;

   multi_vehicle_arming_supervisor dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // supervisor model state
   mavs_pkg::cfg_type  cfg;
   logic [1:0]         sv_mode;
   logic [3:0]         sv_phase;
   logic [31:0]        sv_phase_ms;
   logic               v_seen [mavs_pkg::MAX_DRONES];
   logic               v_armed [mavs_pkg::MAX_DRONES];
   logic [15:0]        v_count [mavs_pkg::MAX_DRONES];
   logic signed [23:0] v_x [mavs_pkg::MAX_DRONES];
   logic signed [23:0] v_y [mavs_pkg::MAX_DRONES];
   logic signed [23:0] v_z [mavs_pkg::MAX_DRONES];
   logic [31:0]        v_stamp [mavs_pkg::MAX_DRONES];

   mavs_pkg::rsp_data_type pending_rsp[$];
   int   errors = 0;
   int   cycles = 0;
   int   beats_sent = 0;
   int   results_seen = 0;
   int   arm_events = 0;
   bit   quiet = 1'b0;
   logic [31:0] now_ms = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("** multi_vehicle_arming_supervisor: FAILED **");
         $finish;
      end
   end

   function automatic int fleet_size();
      if (cfg.vehicle_cnt < 1) return 1;
      if (cfg.vehicle_cnt > mavs_pkg::MAX_DRONES) return mavs_pkg::MAX_DRONES;
      return int'(cfg.vehicle_cnt);
   endfunction

   function automatic bit fleet_ready(int n, logic [31:0] t);
      longint unsigned lim, d2, dx, dy, dz;
      lim = longint'(cfg.min_separation_mm) * longint'(cfg.min_separation_mm);
      for (int i = 0; i < n; i++) begin
         if (!v_seen[i] || v_count[i] < cfg.stability_reports) return 0;
         if (32'(t - v_stamp[i]) > {12'd0, cfg.peer_timeout_ms}) return 0;
      end
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++) begin
            dx = longint'(v_x[i]) - longint'(v_x[j]);
            dy = longint'(v_y[i]) - longint'(v_y[j]);
            dz = longint'(v_z[i]) - longint'(v_z[j]);
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 < lim) return 0;
         end
      return 1;
   endfunction

   function automatic mavs_pkg::rsp_data_type mk_ev(logic [1:0] kind, logic [3:0] tgt,
                                                    logic rej, logic last);
      mavs_pkg::rsp_data_type ev;
      ev = '0;
      ev.event_kind = kind;
      ev.target_drone = tgt;
      ev.report_rejected = rej;
      ev.last_of_run = last;
      return ev;
   endfunction

   task automatic push_arming(int n, ref mavs_pkg::rsp_data_type evs[$]);
      evs.insert(evs.size(), mk_ev(mavs_pkg::EV_CLEARANCE, 4'd0, 1'b0, 1'b0));
      for (int i = 0; i < n; i++)
         if (!v_armed[i])
            evs.insert(evs.size(), mk_ev(mavs_pkg::EV_ARM_CMD, 4'(i + 1), 1'b0, 1'b0));
   endtask

   task automatic predict_supervisor(mavs_pkg::req_data_type r);
      mavs_pkg::rsp_data_type evs[$];
      int  n;
      bit  rej, all_arm;
      n = fleet_size();
      rej = 0;
      if (r.cmd == mavs_pkg::CMD_REPORT) begin
         if (r.topic_slot < 1 || r.topic_slot > n || r.reported_id != {4'd0, r.topic_slot}
             || !r.coords_finite) begin
            rej = 1;
         end else begin
            v_x[r.topic_slot - 1] = r.pos_x;
            v_y[r.topic_slot - 1] = r.pos_y;
            v_z[r.topic_slot - 1] = r.pos_z;
            v_seen[r.topic_slot - 1] = 1;
            if (v_count[r.topic_slot - 1] != mavs_pkg::COUNT_MAX)
               v_count[r.topic_slot - 1] = v_count[r.topic_slot - 1] + 16'd1;
            v_armed[r.topic_slot - 1] = (r.reported_arm_state == mavs_pkg::ARM_STATE_ARMED);
            v_stamp[r.topic_slot - 1] = r.time_ms;
         end
      end else begin
         sv_phase = (sv_phase >= mavs_pkg::TICK_LAST_PHASE) ? 4'd0 : sv_phase + 4'd1;
         if (sv_mode == mavs_pkg::MODE_MESH) begin
            if (fleet_ready(n, r.time_ms)) begin
               sv_mode = mavs_pkg::MODE_ARMING;
               sv_phase_ms = r.time_ms;
               push_arming(n, evs);
            end
         end else if (sv_mode == mavs_pkg::MODE_ARMING) begin
            all_arm = 1;
            for (int i = 0; i < n; i++) if (!v_armed[i]) all_arm = 0;
            if (all_arm) begin
               sv_mode = mavs_pkg::MODE_ARMED;
               evs.insert(evs.size(), mk_ev(mavs_pkg::EV_MISSION, 4'd0, 1'b0, 1'b0));
            end else begin
               if (sv_phase == 0) push_arming(n, evs);
               if (32'(r.time_ms - sv_phase_ms) > {12'd0, cfg.arm_timeout_ms})
                  sv_mode = mavs_pkg::MODE_FAULT;
            end
         end
      end
      evs.insert(evs.size(), mk_ev(mavs_pkg::EV_STATUS, 4'd0, rej, 1'b1));
      foreach (evs[k]) begin
         evs[k].manager_state = sv_mode;
         pending_rsp.insert(pending_rsp.size(), evs[k]);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      mavs_pkg::rsp_data_type exp_rsp;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_data.event_kind != mavs_pkg::EV_STATUS) arm_events++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.event_kind !== exp_rsp.event_kind) begin
               $error("event_kind exp %0d got %0d", exp_rsp.event_kind, rsp_data.event_kind);
               errors++;
            end
            if (rsp_data.target_drone !== exp_rsp.target_drone) begin
               $error("target_drone exp %0d got %0d", exp_rsp.target_drone,
                      rsp_data.target_drone);
               errors++;
            end
            if (rsp_data.manager_state !== exp_rsp.manager_state) begin
               $error("manager_state exp %0d got %0d", exp_rsp.manager_state,
                      rsp_data.manager_state);
               errors++;
            end
            if (rsp_data.report_rejected !== exp_rsp.report_rejected) begin
               $error("report_rejected exp %0d got %0d", exp_rsp.report_rejected,
                      rsp_data.report_rejected);
               errors++;
            end
            if (rsp_data.last_of_run !== exp_rsp.last_of_run) begin
               $error("last_of_run exp %0d got %0d", exp_rsp.last_of_run,
                      rsp_data.last_of_run);
               errors++;
            end
         end
      end
   end

   // busy read right after an edge is the value the block saw at that edge
   task automatic send_beat(mavs_pkg::req_data_type r);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_supervisor(r);
      beats_sent++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic write_csr(logic [mavs_pkg::CSR_IDX_W-1:0] idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[mavs_pkg::CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mavs_pkg::CSR_VEHICLE_CNT:  cfg.vehicle_cnt = val[3:0];
         mavs_pkg::CSR_STABILITY:    cfg.stability_reports = val[15:0];
         mavs_pkg::CSR_ARM_TIMEOUT:  cfg.arm_timeout_ms = val[19:0];
         mavs_pkg::CSR_PEER_TIMEOUT: cfg.peer_timeout_ms = val[19:0];
         mavs_pkg::CSR_MIN_SEP:      cfg.min_separation_mm = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic mavs_pkg::req_data_type mk_report(int slot, int id, int x, int y,
                                                        int z, bit fin, int arm,
                                                        logic [31:0] t);
      mavs_pkg::req_data_type r;
      r = '0;
      r.cmd = mavs_pkg::CMD_REPORT;
      r.topic_slot = 4'(slot);
      r.reported_id = 8'(id);
      r.pos_x = 24'(x);
      r.pos_y = 24'(y);
      r.pos_z = 24'(z);
      r.coords_finite = fin;
      r.reported_arm_state = 8'(arm);
      r.time_ms = t;
      return r;
   endfunction

   function automatic mavs_pkg::req_data_type mk_tick(logic [31:0] t);
      mavs_pkg::req_data_type r;
      r = '0;
      r.cmd = mavs_pkg::CMD_TICK;
      r.topic_slot = 4'($urandom_range(0, 15));
      r.reported_id = 8'($urandom);
      r.time_ms = t;
      return r;
   endfunction

   task automatic test_rejects();
      send_beat(mk_report(0, 0, 0, 0, 0, 1, 2, now_ms));
      send_beat(mk_report(4, 4, 0, 0, 0, 1, 2, now_ms));
      send_beat(mk_report(15, 15, 0, 0, 0, 1, 2, now_ms));
      send_beat(mk_report(2, 3, 0, 0, 0, 1, 2, now_ms));
      send_beat(mk_report(1, 1, 0, 0, 0, 0, 2, now_ms));
      send_beat(mk_report(1, 255, 0, 0, 0, 1, 2, now_ms));
      send_beat(mk_tick(now_ms));
   endtask

   // full arming with extreme coordinates, then mission ready
   task automatic test_arm_sequence();
      write_csr(mavs_pkg::CSR_VEHICLE_CNT, 2);
      write_csr(mavs_pkg::CSR_STABILITY, 1);
      write_csr(mavs_pkg::CSR_MIN_SEP, 65535);
      now_ms = 32'hFFFF_FF00;
      send_beat(mk_report(1, 1, -8388608, -8388608, -8388608, 1, 0, now_ms));
      send_beat(mk_report(2, 2, 8388607, 8388607, 8388607, 1, 255, now_ms));
      now_ms += 200;
      send_beat(mk_tick(now_ms));
      send_beat(mk_report(1, 1, -8388608, -8388608, -8388608, 1, 2, now_ms));
      send_beat(mk_report(2, 2, 8388607, 8388607, 8388607, 1, 2, now_ms));
      send_beat(mk_tick(now_ms));
      send_beat(mk_tick(now_ms));
      send_beat(mk_report(2, 2, 1, 2, 3, 1, 0, now_ms));
      drain();
   endtask

   task automatic test_random_sessions();
      int n, sess;
      for (sess = 0; sess < 8 && beats_sent < 125; sess++) begin
         drain();
         case (sess % 4)
            0: write_csr(mavs_pkg::CSR_VEHICLE_CNT, 8);
            1: write_csr(mavs_pkg::CSR_VEHICLE_CNT, 0);
            2: write_csr(mavs_pkg::CSR_VEHICLE_CNT, 15);
            default: write_csr(mavs_pkg::CSR_VEHICLE_CNT, int'($urandom_range(1, 8)));
         endcase
         write_csr(mavs_pkg::CSR_STABILITY,
                   (sess == 5) ? 65535 : int'($urandom_range(0, 2)));
         write_csr(mavs_pkg::CSR_ARM_TIMEOUT,
                   (sess % 3 == 0) ? 1048575 : int'($urandom_range(0, 3000)));
         write_csr(mavs_pkg::CSR_PEER_TIMEOUT,
                   (sess == 6) ? 0 : ((sess == 2) ? 1048575
                                                  : int'($urandom_range(500, 5000))));
         write_csr(mavs_pkg::CSR_MIN_SEP, (sess == 4) ? 0 : int'($urandom_range(0, 4000)));
         n = fleet_size();
         repeat (6) begin
            if ($urandom_range(0, 3) == 0) begin
               now_ms += $urandom_range(0, 400);
               send_beat(mk_tick(now_ms));
            end else if ($urandom_range(0, 7) == 0) begin
               send_beat(mk_report(int'($urandom_range(0, 15)), int'($urandom),
                                   int'($urandom), int'($urandom), int'($urandom),
                                   1'($urandom_range(0, 1)), int'($urandom), $urandom));
            end else begin
               int s;
               s = int'($urandom_range(1, n));
               send_beat(mk_report(s, s, s * 5000 - 20000 + int'($urandom_range(0, 800)),
                                   int'($urandom_range(0, 3000)) - 1500, int'($urandom), 1,
                                   ($urandom_range(0, 2) != 0) ? 2
                                                               : int'($urandom_range(0, 255)),
                                   now_ms + $urandom_range(0, 100)));
            end
         end
         repeat (5) begin
            now_ms += $urandom_range(100, 300);
            send_beat(mk_tick(now_ms));
         end
      end
   endtask

   initial begin
      cfg = '{mavs_pkg::RST_VEHICLE_CNT, mavs_pkg::RST_STABILITY, mavs_pkg::RST_ARM_TIMEOUT,
              mavs_pkg::RST_PEER_TIMEOUT, mavs_pkg::RST_MIN_SEP};
      sv_mode = mavs_pkg::MODE_MESH;
      sv_phase = 0;
      sv_phase_ms = 0;
      for (int i = 0; i < mavs_pkg::MAX_DRONES; i++) begin
         v_seen[i] = 0; v_armed[i] = 0; v_count[i] = 0;
         v_x[i] = 0; v_y[i] = 0; v_z[i] = 0; v_stamp[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_rejects();
      drain();
      test_arm_sequence();
      test_random_sessions();
      quiet = 1'b1;
      repeat (10) begin
         now_ms += 200;
         send_beat(mk_tick(now_ms));
      end
      drain();
      $display("Covered rejects, a full arming run with extreme positions and random");
      $display("sessions: %0d beats in, %0d results checked (%0d non-status events).",
               beats_sent, results_seen, arm_events);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("** multi_vehicle_arming_supervisor: PASSED **");
      else
         $display("** multi_vehicle_arming_supervisor: FAILED **");
      $finish;
   end
endmodule
